### rtl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types and codes for the MIDI byte stream parser: message kinds,
// parse phases, the classified byte item and the result record.
// ----------------------------------------------------------------------------
package mbsp_pkg;

  // message kind codes
  localparam logic [3:0] KIND_CC        = 4'd3;
  localparam logic [3:0] KIND_PROG      = 4'd4;
  localparam logic [3:0] KIND_CHANPRESS = 4'd5;
  localparam logic [3:0] KIND_COMMON    = 4'd7;
  localparam logic [3:0] KIND_REALTIME  = 4'd8;
  localparam logic [3:0] KIND_CHANMODE  = 4'd9;

  // system common subtypes
  localparam logic [2:0] COMMON_SYSEX_START = 3'd0;
  localparam logic [2:0] COMMON_TIME_CODE   = 3'd1;
  localparam logic [2:0] COMMON_SONG_SELECT = 3'd3;

  // special bytes and limits
  localparam logic [7:0] BYTE_EOX       = 8'hF7;
  localparam logic [6:0] CC_LAST_NORMAL = 7'd119;
  localparam logic [6:0] CHANMODE_BASE  = 7'd120;

  // parser phase
  typedef enum logic [1:0] {
    PH_EMPTY  = 2'd0,
    PH_STATUS = 2'd1,
    PH_DATA0  = 2'd2,
    PH_SYSEX  = 2'd3
  } mbsp_phase_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0] raw;
    logic       is_status;
    logic       is_eox;
    logic       is_common;
    logic       is_realtime;
    logic [3:0] kind;
    logic [3:0] channel;
  } mbsp_item_t;

  // one result transaction
  typedef struct packed {
    logic       message_ready;
    logic [3:0] message_kind;
    logic [3:0] channel_number;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [2:0] sub_kind;
    logic [7:0] sysex_count;
    logic       sysex_byte_valid;
    logic [6:0] sysex_position;
    logic [7:0] sysex_byte;
  } mbsp_result_t;

endpackage

### rtl/mbsp_front.sv
// ----------------------------------------------------------------------------
// mbsp_front
// Input side: takes raw bytes and classifies them before they enter the
// queue toward the parser core.
// ----------------------------------------------------------------------------
module mbsp_front import mbsp_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_midi_byte,
  input  logic       q_full,
  output logic       q_push,
  output mbsp_item_t q_item
);

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // split the byte into status flags, kind and channel
  always_comb begin
    q_item             = '0;
    q_item.raw         = in_midi_byte;
    q_item.is_status   = in_midi_byte[7];
    q_item.is_eox      = (in_midi_byte == BYTE_EOX);
    q_item.kind        = {1'b0, in_midi_byte[6:4]};
    q_item.channel     = in_midi_byte[3:0];
    q_item.is_common   = in_midi_byte[7] && ({1'b0, in_midi_byte[6:4]} == KIND_COMMON);
    q_item.is_realtime = q_item.is_common && in_midi_byte[3];
  end

endmodule

### rtl/mbsp_queue.sv
// ----------------------------------------------------------------------------
// mbsp_queue
// Two-entry queue of classified bytes between the front and the parser core.
// ----------------------------------------------------------------------------
module mbsp_queue import mbsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mbsp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output mbsp_item_t head_item
);

  mbsp_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_item = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/mbsp_back.sv
// ----------------------------------------------------------------------------
// mbsp_back
// Parser core: running status state machine, data byte collection, SysEx
// payload indexing and the registered result stage.
// ----------------------------------------------------------------------------
module mbsp_back import mbsp_pkg::*; #(
  parameter int SYSEX_CAPACITY = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_not_empty,
  input  mbsp_item_t   q_item,
  output logic         q_pop,
  output logic         res_valid,
  input  logic         res_ready,
  output mbsp_result_t res
);

  localparam logic [7:0] SysexCap = 8'(SYSEX_CAPACITY);

  mbsp_phase_t  phase_r, phase_nxt;
  logic [3:0]   running_r, running_nxt;
  logic [3:0]   kind_r, kind_nxt;
  logic [3:0]   chan_r, chan_nxt;
  logic [6:0]   first_r, first_nxt;
  logic [6:0]   second_r, second_nxt;
  logic [2:0]   common_sub_r, common_sub_nxt;
  logic [2:0]   sub_r, sub_nxt;
  logic [7:0]   sx_count_r, sx_count_nxt;
  logic         out_valid_r, out_valid_nxt;
  mbsp_result_t res_r, res_nxt;
  logic         msg_ready;
  logic         sx_valid;
  logic         one_byte;
  logic [6:0]   data7;
  logic [6:0]   mode_sub;

  // pop when the result stage is free or being drained
  assign q_pop     = q_not_empty && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;
  assign data7     = q_item.raw[6:0];
  assign mode_sub  = data7 - CHANMODE_BASE;

  // one data byte messages
  assign one_byte = (running_r == KIND_CHANPRESS) || (running_r == KIND_PROG) ||
                    ((running_r == KIND_COMMON) &&
                     ((common_sub_r == COMMON_TIME_CODE) ||
                      (common_sub_r == COMMON_SONG_SELECT)));

  // next state of the parser
  always_comb begin
    phase_nxt      = phase_r;
    running_nxt    = running_r;
    kind_nxt       = kind_r;
    chan_nxt       = chan_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    common_sub_nxt = common_sub_r;
    sub_nxt        = sub_r;
    sx_count_nxt   = sx_count_r;
    msg_ready      = 1'b0;
    sx_valid       = 1'b0;
    if (q_pop) begin
      case (phase_r)
        PH_EMPTY: begin
          if (q_item.is_status) begin
            chan_nxt    = q_item.channel;
            kind_nxt    = q_item.kind;
            first_nxt   = '0;
            second_nxt  = '0;
            running_nxt = q_item.kind;
            phase_nxt   = PH_STATUS;
            if (q_item.is_common) begin
              chan_nxt = '0;
              if (q_item.is_realtime) begin
                kind_nxt    = KIND_REALTIME;
                running_nxt = KIND_REALTIME;
                sub_nxt     = q_item.raw[2:0];
                phase_nxt   = PH_EMPTY;
                msg_ready   = 1'b1;
              end else begin
                common_sub_nxt = q_item.raw[2:0];
                if (q_item.raw[2:0] == COMMON_SYSEX_START) begin
                  phase_nxt    = PH_SYSEX;
                  sx_count_nxt = '0;
                end else if (q_item.raw[2:0] > COMMON_SONG_SELECT) begin
                  phase_nxt = PH_EMPTY;
                  msg_ready = 1'b1;
                end
              end
            end
          end else begin
            // running status data byte
            kind_nxt   = running_r;
            first_nxt  = data7;
            second_nxt = '0;
            phase_nxt  = PH_DATA0;
          end
        end
        PH_STATUS: begin
          if (!q_item.is_status) begin
            first_nxt = data7;
            if (one_byte) begin
              phase_nxt = PH_EMPTY;
              msg_ready = 1'b1;
            end else begin
              phase_nxt = PH_DATA0;
            end
            if ((running_r == KIND_CC) && (data7 > CC_LAST_NORMAL)) begin
              kind_nxt    = KIND_CHANMODE;
              running_nxt = KIND_CHANMODE;
              sub_nxt     = mode_sub[2:0];
            end
          end else begin
            phase_nxt = PH_EMPTY;
          end
        end
        PH_DATA0: begin
          if (!q_item.is_status) begin
            second_nxt = data7;
            msg_ready  = 1'b1;
          end
          phase_nxt = PH_EMPTY;
        end
        PH_SYSEX: begin
          if (q_item.is_eox) begin
            phase_nxt = PH_EMPTY;
            msg_ready = 1'b1;
          end else if (sx_count_r < SysexCap) begin
            sx_valid     = 1'b1;
            sx_count_nxt = sx_count_r + 8'd1;
          end
        end
        default: begin
          phase_nxt = PH_EMPTY;
        end
      endcase
    end
  end

  // assemble the result record
  always_comb begin
    res_nxt             = '0;
    res_nxt.sysex_count = sx_count_nxt;
    if (msg_ready) begin
      res_nxt.message_ready  = 1'b1;
      res_nxt.message_kind   = kind_nxt;
      res_nxt.channel_number = chan_nxt;
      res_nxt.first_data     = first_nxt;
      res_nxt.second_data    = second_nxt;
      if (kind_nxt == KIND_COMMON) begin
        res_nxt.sub_kind = common_sub_nxt;
      end else if ((kind_nxt == KIND_REALTIME) || (kind_nxt == KIND_CHANMODE)) begin
        res_nxt.sub_kind = sub_nxt;
      end
    end
    if (sx_valid) begin
      res_nxt.sysex_byte_valid = 1'b1;
      res_nxt.sysex_position   = sx_count_r[6:0];
      res_nxt.sysex_byte       = q_item.raw;
    end
  end

  // result stage handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_EMPTY;
      running_r    <= '0;
      kind_r       <= '0;
      chan_r       <= '0;
      first_r      <= '0;
      second_r     <= '0;
      common_sub_r <= '0;
      sub_r        <= '0;
      sx_count_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      running_r    <= running_nxt;
      kind_r       <= kind_nxt;
      chan_r       <= chan_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      common_sub_r <= common_sub_nxt;
      sub_r        <= sub_nxt;
      sx_count_r   <= sx_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/midi_byte_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit
// MIDI byte stream parser with running status and SysEx payload indexing.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw MIDI byte per transaction (valid/ready).
//   out_* : exactly one result transaction per input byte, in order. A result
//           carries a complete message when out_message_ready is 1, and a
//           stored SysEx payload byte when out_sysex_byte_valid is 1; the
//           SysEx count is given on every result.
//   Path: an accepted byte passes one queue stage, then the registered
//   result stage.
//   Throughput: one byte per cycle while out_ready stays high; each byte is
//   one pass of the parser state machine in the core.
//   Stalls: a two-entry queue sits between the input side and the core, and
//   the result register holds its transaction while out_ready is low; in_ready
//   drops only when the queue is full.
//   Reset (rst_n low, synchronous): parser empty, running status and held
//   message fields cleared, SysEx count zero, queue and result stage empty.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit import mbsp_pkg::*; #(
  parameter int SYSEX_CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_midi_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_message_ready,
  output logic [3:0] out_message_kind,
  output logic [3:0] out_channel_number,
  output logic [6:0] out_first_data,
  output logic [6:0] out_second_data,
  output logic [2:0] out_sub_kind,
  output logic [7:0] out_sysex_count,
  output logic       out_sysex_byte_valid,
  output logic [6:0] out_sysex_position,
  output logic [7:0] out_sysex_byte
);

  logic         q_full;
  logic         q_push;
  logic         q_pop;
  logic         q_not_empty;
  mbsp_item_t   push_item;
  mbsp_item_t   head_item;
  mbsp_result_t res;

  // classify incoming bytes
  mbsp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_midi_byte (in_midi_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // decoupling queue
  mbsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // parser core and result stage
  mbsp_back #(
    .SYSEX_CAPACITY (SYSEX_CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .res         (res)
  );

  // unpack the result record
  assign out_message_ready    = res.message_ready;
  assign out_message_kind     = res.message_kind;
  assign out_channel_number   = res.channel_number;
  assign out_first_data       = res.first_data;
  assign out_second_data      = res.second_data;
  assign out_sub_kind         = res.sub_kind;
  assign out_sysex_count      = res.sysex_count;
  assign out_sysex_byte_valid = res.sysex_byte_valid;
  assign out_sysex_position   = res.sysex_position;
  assign out_sysex_byte       = res.sysex_byte;

endmodule

### bench/midi_byte_stream_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit_tb
// Feeds raw MIDI byte streams (directed messages, then random well-formed
// messages with noise and broken sequences) through the parser. A local
// parser model predicts one result per accepted byte, and every result
// transaction is checked field by field against it. Both handshakes idle at
// random, and the result side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit_tb import mbsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYSEX_CAPACITY = 128;
  localparam int RANDOM_BYTES   = 1600;
  localparam int IDLE_PERCENT   = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_midi_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_message_ready;
  logic [3:0] out_message_kind;
  logic [3:0] out_channel_number;
  logic [6:0] out_first_data;
  logic [6:0] out_second_data;
  logic [2:0] out_sub_kind;
  logic [7:0] out_sysex_count;
  logic       out_sysex_byte_valid;
  logic [6:0] out_sysex_position;
  logic [7:0] out_sysex_byte;

  // bytes waiting to be sent and results waiting to be seen
  logic [7:0]   midi_bytes_to_send[$];
  mbsp_result_t expected_results[$];

  int bytes_accepted  = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  // parser model state
  mbsp_phase_t parse_at;
  logic [3:0]  run_status;
  logic [3:0]  msg_kind;
  logic [3:0]  msg_channel;
  logic [6:0]  data_a;
  logic [6:0]  data_b;
  logic [2:0]  common_sub;
  logic [2:0]  aux_sub;
  logic [7:0]  sx_count;

  midi_byte_stream_parser_unit #(
    .SYSEX_CAPACITY(SYSEX_CAPACITY)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_midi_byte        (in_midi_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_message_ready   (out_message_ready),
    .out_message_kind    (out_message_kind),
    .out_channel_number  (out_channel_number),
    .out_first_data      (out_first_data),
    .out_second_data     (out_second_data),
    .out_sub_kind        (out_sub_kind),
    .out_sysex_count     (out_sysex_count),
    .out_sysex_byte_valid(out_sysex_byte_valid),
    .out_sysex_position  (out_sysex_position),
    .out_sysex_byte      (out_sysex_byte)
  );

  // clock
  always #5 clk = ~clk;

  // advance the parser model by one byte and queue the result it gives
  task automatic parse_midi_byte(input logic [7:0] midi_in);
    mbsp_result_t r;
    logic         one_byte;
    r = '0;
    case (parse_at)
      PH_EMPTY: begin
        if (midi_in[7]) begin
          msg_channel = midi_in[3:0];
          msg_kind    = {1'b0, midi_in[6:4]};
          data_a      = '0;
          data_b      = '0;
          run_status  = msg_kind;
          parse_at    = PH_STATUS;
          if (msg_kind == KIND_COMMON) begin
            msg_channel = '0;
            if (midi_in[3]) begin
              // real-time goes out at once and becomes running status
              msg_kind  = KIND_REALTIME;
              run_status = KIND_REALTIME;
              aux_sub   = midi_in[2:0];
              parse_at  = PH_EMPTY;
              r.message_ready = 1'b1;
            end else begin
              common_sub = midi_in[2:0];
              if (common_sub == COMMON_SYSEX_START) begin
                parse_at = PH_SYSEX;
                sx_count = '0;
              end else if (common_sub > COMMON_SONG_SELECT) begin
                parse_at = PH_EMPTY;
                r.message_ready = 1'b1;
              end
            end
          end
        end else begin
          // running status: always waits for a second data byte
          msg_kind = run_status;
          data_a   = midi_in[6:0];
          data_b   = '0;
          parse_at = PH_DATA0;
        end
      end
      PH_STATUS: begin
        if (!midi_in[7]) begin
          data_a   = midi_in[6:0];
          one_byte = run_status == KIND_CHANPRESS || run_status == KIND_PROG ||
                     (run_status == KIND_COMMON &&
                      (common_sub == COMMON_TIME_CODE || common_sub == COMMON_SONG_SELECT));
          if (one_byte) begin
            parse_at = PH_EMPTY;
            r.message_ready = 1'b1;
          end else begin
            parse_at = PH_DATA0;
          end
          // control numbers above 119 are channel-mode messages
          if (run_status == KIND_CC && data_a > CC_LAST_NORMAL) begin
            msg_kind   = KIND_CHANMODE;
            run_status = KIND_CHANMODE;
            aux_sub    = 3'(data_a - CHANMODE_BASE);
          end
        end else begin
          parse_at = PH_EMPTY;
        end
      end
      PH_DATA0: begin
        if (!midi_in[7]) begin
          data_b = midi_in[6:0];
          r.message_ready = 1'b1;
        end
        parse_at = PH_EMPTY;
      end
      default: begin
        if (midi_in == BYTE_EOX) begin
          parse_at = PH_EMPTY;
          r.message_ready = 1'b1;
        end else if (sx_count < SYSEX_CAPACITY) begin
          r.sysex_byte_valid = 1'b1;
          r.sysex_position   = sx_count[6:0];
          r.sysex_byte       = midi_in;
          sx_count           = sx_count + 8'd1;
        end
      end
    endcase
    if (r.message_ready) begin
      r.message_kind   = msg_kind;
      r.channel_number = msg_channel;
      r.first_data     = data_a;
      r.second_data    = data_b;
      if (msg_kind == KIND_COMMON) begin
        r.sub_kind = common_sub;
      end else if (msg_kind == KIND_REALTIME || msg_kind == KIND_CHANMODE) begin
        r.sub_kind = aux_sub;
      end
    end
    r.sysex_count = sx_count;
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic send(input logic [7:0] midi_in);
    midi_bytes_to_send.push_back(midi_in);
  endtask

  function automatic logic [7:0] data_value();
    return 8'($urandom_range(0, 127));
  endfunction

  // one random message, mostly well formed, sometimes broken or noise
  task automatic queue_random_message();
    int         pick;
    int         kind;
    int         len;
    logic [7:0] sx;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // channel voice message, maybe followed by running-status pairs
      kind = $urandom_range(0, 6);
      send({1'b1, 3'(kind), 4'($urandom_range(0, 15))});
      if (kind == KIND_CC && $urandom_range(0, 3) == 0) begin
        send(8'($urandom_range(120, 127)));
      end else begin
        send(data_value());
      end
      if (kind != KIND_PROG && kind != KIND_CHANPRESS) begin
        send(data_value());
      end
      repeat ($urandom_range(0, 3)) begin
        send(data_value());
        send(data_value());
      end
    end else if (pick < 60) begin
      // system common other than sysex
      kind = $urandom_range(1, 6);
      send({5'b11110, 3'(kind)});
      if (kind <= COMMON_SONG_SELECT) begin
        send(data_value());
      end
      if (kind == 2) begin
        send(data_value());
      end
    end else if (pick < 70) begin
      // real-time, sometimes used as running status
      send({5'b11111, 3'($urandom_range(0, 7))});
      if ($urandom_range(0, 2) == 0) begin
        send(data_value());
        send(data_value());
      end
    end else if (pick < 80) begin
      // sysex, rarely long enough to overflow
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 12);
      send({5'b11110, COMMON_SYSEX_START});
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) begin
          sx = 8'($urandom_range(128, 255));
          if (sx == BYTE_EOX) begin
            sx = 8'hF8;
          end
          send(sx);
        end else begin
          send(data_value());
        end
      end
      send(BYTE_EOX);
    end else if (pick < 90) begin
      // truncated two-byte message, cut off by the next status
      send({1'b1, 3'($urandom_range(0, 3)), 4'($urandom_range(0, 15))});
      if ($urandom_range(0, 1) == 0) begin
        send(data_value());
      end
      send({1'b1, 7'($urandom_range(0, 127))});
    end else begin
      // noise
      send(8'($urandom_range(0, 255)));
    end
  endtask

  // input driver: predicts each accepted byte, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        parse_midi_byte(in_midi_byte);
        bytes_accepted++;
      end
      if (midi_bytes_to_send.size() > 0 &&
          ((bytes_accepted >= 700 && bytes_accepted < 1000) ||
           $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        in_midi_byte <= midi_bytes_to_send.pop_front();
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall control
  always @(posedge clk) begin
    mbsp_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transaction with no expectation waiting", $time);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("message_ready", want.message_ready, out_message_ready);
          compare_field("message_kind", want.message_kind, out_message_kind);
          compare_field("channel_number", want.channel_number, out_channel_number);
          compare_field("first_data", want.first_data, out_first_data);
          compare_field("second_data", want.second_data, out_second_data);
          compare_field("sub_kind", want.sub_kind, out_sub_kind);
          compare_field("sysex_count", want.sysex_count, out_sysex_count);
          compare_field("sysex_byte_valid", want.sysex_byte_valid, out_sysex_byte_valid);
          compare_field("sysex_position", want.sysex_position, out_sysex_position);
          compare_field("sysex_byte", want.sysex_byte, out_sysex_byte);
        end
        results_checked++;
      end
      // one long hold-off so the input queue fills up and backpressures
      if (!hold_done && results_checked >= 400) begin
        hold_done = 1'b1;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_checked >= 1100 && results_checked < 1400) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // stimulus and end of test
  initial begin
    int directed_bytes;
    parse_at    = PH_EMPTY;
    run_status  = '0;
    msg_kind    = '0;
    msg_channel = '0;
    data_a      = '0;
    data_b      = '0;
    common_sub  = '0;
    aux_sub     = '0;
    sx_count    = '0;

    // note on with data extremes, then a running-status pair
    send(8'h90); send(8'h00); send(8'h7F);
    send(8'h01); send(8'h7F);
    // note off cut short by a status byte, then cc 119
    send(8'h8F); send(8'h40);
    send(8'hB5); send(8'h77); send(8'h01);
    // status after status is dropped
    send(8'hA3); send(8'hB5);
    // channel mode at both ends of its range
    send(8'hB5); send(8'h78); send(8'h00);
    send(8'hB5); send(8'h7F); send(8'h7F);
    // one-byte voice messages and pitch bend
    send(8'hC2); send(8'h55);
    send(8'hD9); send(8'h33);
    send(8'hEE); send(8'h2A); send(8'h15);
    // system common with one, two and no data bytes
    send(8'hF1); send(8'h12);
    send(8'hF2); send(8'h01); send(8'h02);
    send(8'hF3); send(8'h05);
    send(8'hF4); send(8'hF5); send(8'hF6);
    // real-time, then reused as running status
    send(8'hF8); send(8'hFF);
    send(8'h10); send(8'h20);
    // short sysex holding a status byte as payload
    send(8'hF0); send(8'h01); send(8'hFF); send(8'h7F); send(8'hF7);
    // sysex past capacity
    send(8'hF0);
    repeat (SYSEX_CAPACITY + 4) send(data_value());
    send(BYTE_EOX);

    directed_bytes = midi_bytes_to_send.size();
    while (midi_bytes_to_send.size() < directed_bytes + RANDOM_BYTES) begin
      queue_random_message();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (midi_bytes_to_send.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
rtl/mbsp_pkg.sv
rtl/mbsp_front.sv
rtl/mbsp_queue.sv
rtl/mbsp_back.sv
rtl/midi_byte_stream_parser_unit.sv
bench/midi_byte_stream_parser_unit_tb.sv
